FILE: hdl/file_cache_block_status_table_top_macros.svh
// Assertion macros shared by the table modules.
`ifndef FILE_CACHE_BLOCK_STATUS_TABLE_TOP_MACROS_SVH
`define FILE_CACHE_BLOCK_STATUS_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define FCBST_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define FCBST_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define FCBST_ASSERT(name, clk, rst_n, prop)
`define FCBST_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

FILE: hdl/fcbst_pkg.sv
package fcbst_pkg;

  localparam int unsigned MAX_BLOCKS_DEF     = 1024;
  localparam int unsigned MAX_BLOCK_LOG2_DEF = 16;

  localparam int unsigned CFG_W    = 5;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MARK_W   = 2;

  localparam logic [CFG_W-1:0] BLOCK_SIZE_LOG2_RST = CFG_W'(9);

  typedef enum logic [KIND_W-1:0] {
    KIND_REQUEST = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_LENGTH = 2'd2
  } status_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic  in_range;
    logic  rel_valid;
    logic  rel_dirty;
  } item_ctrl_t;

endpackage

FILE: hdl/fcbst_ram.sv
module fcbst_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/fcbst_update.sv
`include "file_cache_block_status_table_top_macros.svh"

module fcbst_update
  import fcbst_pkg::*;
#(
  parameter int unsigned MaxBlocks    = MAX_BLOCKS_DEF,
  parameter int unsigned MaxBlockLog2 = MAX_BLOCK_LOG2_DEF,
  localparam int unsigned AW = $clog2(MaxBlocks),
  localparam int unsigned EW = AW + 1,
  localparam int unsigned OW = MaxBlockLog2,
  localparam int unsigned LW = MaxBlockLog2 + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  item_ctrl_t          ctrl_i,
  input  logic [AW-1:0]       blk_i,
  input  logic [OW-1:0]       owb_i,
  input  logic [LW-1:0]       bsize_i,
  input  logic [LEN_W-1:0]    rlen_i,
  input  logic [MARK_W-1:0]   mark_i,
  output logic                we_o,
  output logic [AW-1:0]       waddr_o,
  output logic [MARK_W-1:0]   wdata_o,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [LEN_W-1:0]    remaining_length_o,
  output logic                block_valid_o,
  output logic                block_dirty_o
);

  localparam int unsigned SW = ((LW > LEN_W) ? LW : LEN_W) + 1;

  logic [EW-1:0]       extent_q, extent_d;
  logic [LW-1:0]       last_q, last_d;
  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [LEN_W-1:0]    remain_q;
  logic                qv_q, qd_q;

  logic [EW-1:0] blk_x, blk_p1, ext_n;
  logic [LW-1:0] last_n, owb_x, remain;
  logic [SW-1:0] end_sum;
  logic          is_last;
  status_e       status;
  logic          qv, qd;

  always_comb begin
    blk_x    = EW'(blk_i);
    blk_p1   = blk_x + EW'(1);
    owb_x    = LW'(owb_i);
    end_sum  = SW'(owb_i) + SW'(rlen_i);
    ext_n    = extent_q;
    last_n   = last_q;
    is_last  = 1'b0;
    remain   = '0;
    status   = ST_OK;
    qv       = 1'b0;
    qd       = 1'b0;
    extent_d = extent_q;
    last_d   = last_q;
    we_o     = 1'b0;
    waddr_o  = blk_i;
    wdata_o  = {ctrl_i.rel_valid & ctrl_i.rel_dirty, ctrl_i.rel_valid};
    if (ctrl_i.valid && ctrl_i.kind != KIND_UNUSED) begin
      if (!ctrl_i.in_range) begin
        status = ST_RANGE;
      end else begin
        case (ctrl_i.kind)
          KIND_REQUEST: begin
            if (blk_x >= extent_q) begin
              ext_n  = blk_p1;
              last_n = '0;
            end
            is_last = (blk_p1 == ext_n);
            if (is_last) begin
              if (owb_x > last_n) begin
                status = ST_LENGTH;
              end else begin
                remain = last_n - owb_x;
              end
            end else begin
              remain = bsize_i - owb_x;
            end
            if (status == ST_OK) begin
              extent_d = ext_n;
              last_d   = last_n;
            end
          end
          KIND_QUERY: begin
            if (blk_x < extent_q) begin
              qv = mark_i[0];
              qd = mark_i[0] & mark_i[1];
            end
          end
          KIND_RELEASE: begin
            if (blk_x >= extent_q) begin
              status = ST_RANGE;
            end else begin
              is_last = (blk_p1 == extent_q);
              if (is_last) begin
                if (end_sum > SW'(bsize_i)) begin
                  status = ST_LENGTH;
                end else begin
                  last_d = LW'(end_sum);
                end
              end
              we_o = (status == ST_OK);
            end
          end
          default: begin
            status = ST_OK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extent_q <= '0;
      last_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      extent_q <= extent_d;
      last_q   <= last_d;
      done_q   <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status;
    remain_q <= LEN_W'(remain);
    qv_q     <= qv;
    qd_q     <= qd;
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign remaining_length_o = remain_q;
  assign block_valid_o      = qv_q;
  assign block_dirty_o      = qd_q;

  `FCBST_ASSERT(a_extent_bounded, clk_i, rst_ni, extent_q <= EW'(MaxBlocks))
  `FCBST_ASSERT(a_extent_grows_only, clk_i, rst_ni, 1'b1 |=> extent_q >= $past(extent_q))
  `FCBST_ASSERT_NEVER(a_dirty_without_valid, clk_i, rst_ni, we_o && wdata_o[1] && !wdata_o[0])

endmodule

FILE: hdl/file_cache_block_status_table_top.sv
// Block status table for a cached file. One item is accepted per clock while busy is low.
// The item is registered at the accepting edge, and its result is registered at the next
// edge; it then sits on the result ports for that one cycle, marked by done_o. The receiver
// cannot hold it off and must capture it then. The throughput of one item per clock comes
// from the single read-modify-write of the mark memory, with the previous item's mark write
// forwarded to a read of the same block. After reset, busy stays high while all MaxBlocks
// entries (1024 by default) of the mark memory are swept clear; configuration writes
// are taken during that sweep.
`include "file_cache_block_status_table_top_macros.svh"

module file_cache_block_status_table_top
  import fcbst_pkg::*;
#(
  parameter int unsigned MaxBlocks    = MAX_BLOCKS_DEF,
  parameter int unsigned MaxBlockLog2 = MAX_BLOCK_LOG2_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [OFFSET_W-1:0] byte_offset_i,
  input  logic [LEN_W-1:0]    release_length_i,
  input  logic                release_valid_i,
  input  logic                release_dirty_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [LEN_W-1:0]    remaining_length_o,
  output logic                block_valid_o,
  output logic                block_dirty_o
);

  localparam int unsigned AW = $clog2(MaxBlocks);
  localparam int unsigned OW = MaxBlockLog2;
  localparam int unsigned LW = MaxBlockLog2 + 1;

  logic [CFG_W-1:0]    cfg_q;
  logic                clearing_q;
  logic [AW-1:0]       clr_addr_q;

  logic                accept;
  logic [CFG_W-1:0]    shift_eff;
  logic [LW-1:0]       bsize_d;
  logic [OW-1:0]       owb_d;
  logic [OFFSET_W-1:0] blk_full;
  logic                in_range_d;
  logic                fwd_d;

  item_ctrl_t          ctrl_q;
  logic [AW-1:0]       blk_q;
  logic [OW-1:0]       owb_q;
  logic [LW-1:0]       bsize_q;
  logic [LEN_W-1:0]    rlen_q;
  logic                fwd_q;
  logic [MARK_W-1:0]   fwd_mark_q;

  logic                upd_we;
  logic [AW-1:0]       upd_waddr;
  logic [MARK_W-1:0]   upd_wdata;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MARK_W-1:0]   ram_wdata;
  logic [MARK_W-1:0]   ram_rdata;
  logic [MARK_W-1:0]   mark;

  assign busy   = clearing_q;
  assign accept = start & ~clearing_q;

  always_comb begin
    shift_eff  = (cfg_q > CFG_W'(MaxBlockLog2)) ? CFG_W'(MaxBlockLog2) : cfg_q;
    bsize_d    = LW'(1) << shift_eff;
    owb_d      = byte_offset_i[OW-1:0] & OW'(bsize_d - LW'(1));
    blk_full   = byte_offset_i >> shift_eff;
    in_range_d = (blk_full < OFFSET_W'(MaxBlocks));
    fwd_d      = upd_we & (upd_waddr == blk_full[AW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= BLOCK_SIZE_LOG2_RST;
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      ctrl_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (clearing_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MaxBlocks - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      ctrl_q.valid <= accept;
      if (accept) begin
        ctrl_q.kind      <= kind_e'(kind_i);
        ctrl_q.in_range  <= in_range_d;
        ctrl_q.rel_valid <= release_valid_i;
        ctrl_q.rel_dirty <= release_dirty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q      <= blk_full[AW-1:0];
      owb_q      <= owb_d;
      bsize_q    <= bsize_d;
      rlen_q     <= release_length_i;
      fwd_q      <= fwd_d;
      fwd_mark_q <= upd_wdata;
    end
  end

  assign ram_we    = clearing_q | upd_we;
  assign ram_waddr = clearing_q ? clr_addr_q : upd_waddr;
  assign ram_wdata = clearing_q ? '0 : upd_wdata;
  assign mark      = fwd_q ? fwd_mark_q : ram_rdata;

  fcbst_ram #(
    .Width (MARK_W),
    .Depth (MaxBlocks)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (blk_full[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  fcbst_update #(
    .MaxBlocks    (MaxBlocks),
    .MaxBlockLog2 (MaxBlockLog2)
  ) u_update (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl_q),
    .blk_i              (blk_q),
    .owb_i              (owb_q),
    .bsize_i            (bsize_q),
    .rlen_i             (rlen_q),
    .mark_i             (mark),
    .we_o               (upd_we),
    .waddr_o            (upd_waddr),
    .wdata_o            (upd_wdata),
    .done_o             (done_o),
    .status_o           (status_o),
    .remaining_length_o (remaining_length_o),
    .block_valid_o      (block_valid_o),
    .block_dirty_o      (block_dirty_o)
  );

  `FCBST_ASSERT(a_done_follows_accept, clk_i, rst_ni, 1'b1 |=> (done_o == $past(accept, 2)))
  `FCBST_ASSERT(a_clear_writes, clk_i, rst_ni, busy |-> ram_we && ram_wdata == '0)
  `FCBST_ASSERT(a_error_quiet, clk_i, rst_ni,
                done_o && status_o != ST_OK |->
                remaining_length_o == '0 && !block_valid_o && !block_dirty_o)

endmodule
